>>> src/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types, constants and decode helpers for the tachometer packet decoder
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int unsigned POS_W     = 5;
  localparam int unsigned READING_W = 17;
  localparam int unsigned DEC_W     = 3;
  localparam int unsigned QTY_W     = 2;

  // byte positions inside a packet
  localparam logic [POS_W-1:0] POS_DIGIT_FIRST = 5'd1;
  localparam logic [POS_W-1:0] POS_DIGIT_LAST  = 5'd10;
  localparam logic [POS_W-1:0] POS_FLAG1_HI    = 5'd21;
  localparam logic [POS_W-1:0] POS_FLAG1_LO    = 5'd22;
  localparam logic [POS_W-1:0] POS_FLAG2_HI    = 5'd23;
  localparam logic [POS_W-1:0] POS_FLAG2_LO    = 5'd24;
  localparam logic [POS_W-1:0] POS_CR          = 5'd25;
  localparam logic [POS_W-1:0] POS_LAST        = 5'd26;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // quantity codes
  localparam logic [QTY_W-1:0] QTY_RPM   = 2'd0;
  localparam logic [QTY_W-1:0] QTY_COUNT = 2'd1;
  localparam logic [QTY_W-1:0] QTY_NONE  = 2'd2;

  localparam int unsigned DP_BIT = 7;

  // seven-segment codes for digits 0 to 9
  localparam logic [6:0] SEG_CODES [10] = '{
    7'h7B, 7'h60, 7'h5E, 7'h7C, 7'h65, 7'h3D, 7'h3F, 7'h70, 7'h7F, 7'h7D
  };

  typedef struct packed {
    logic       hit;
    logic [3:0] digit;
  } seg_digit_t;

  typedef struct packed {
    logic                 packet_ok;
    logic [READING_W-1:0] reading;
    logic [DEC_W-1:0]     decimals;
    logic [QTY_W-1:0]     quantity;
    logic                 hold_mark;
    logic                 minimum_mark;
    logic                 maximum_mark;
    logic                 average_mark;
  } result_t;

  // match a segment pattern against the digit table, no hit counts as zero
  function automatic seg_digit_t seg_decode(input logic [6:0] seg);
    seg_digit_t res;
    res = '0;
    for (int k = 0; k < 10; k++) begin
      if (SEG_CODES[k] == seg) begin
        res.hit   = 1'b1;
        res.digit = 4'(k);
      end
    end
    return res;
  endfunction

  // decimal weight of a digit slot, least significant first
  function automatic logic [READING_W-1:0] digit_weight(input logic [2:0] slot);
    logic [READING_W-1:0] w;
    unique case (slot)
      3'd0:    w = 17'd1;
      3'd1:    w = 17'd10;
      3'd2:    w = 17'd100;
      3'd3:    w = 17'd1000;
      3'd4:    w = 17'd10000;
      default: w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

>>> src/tpd_in_if.sv
// ----------------------------------------------------------------------------
// tpd_in_if
// Byte request channel into the tachometer packet decoder
// ----------------------------------------------------------------------------
interface tpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_start;

  modport source (output valid, output data_byte, output packet_start, input ready);
  modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface

>>> src/tpd_out_if.sv
// ----------------------------------------------------------------------------
// tpd_out_if
// Decoded reading channel out of the tachometer packet decoder
// ----------------------------------------------------------------------------
interface tpd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           packet_ok;
  logic [tpd_pkg::READING_W-1:0]  reading;
  logic [tpd_pkg::DEC_W-1:0]      decimals;
  logic [tpd_pkg::QTY_W-1:0]      quantity;
  logic                           hold_mark;
  logic                           minimum_mark;
  logic                           maximum_mark;
  logic                           average_mark;

  modport source (
    output valid, output packet_ok, output reading, output decimals, output quantity,
    output hold_mark, output minimum_mark, output maximum_mark, output average_mark,
    input ready
  );
  modport sink (
    input valid, input packet_ok, input reading, input decimals, input quantity,
    input hold_mark, input minimum_mark, input maximum_mark, input average_mark,
    output ready
  );
endinterface

>>> src/tpd_frame.sv
// ----------------------------------------------------------------------------
// tpd_frame
// Packet framing state and per-byte decode of digits, flags and trailer
// ----------------------------------------------------------------------------
module tpd_frame (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             packet_start,
  output logic             emit,
  output tpd_pkg::result_t result
);

  logic [tpd_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [7:0]                    pair_r, pair_nxt;
  logic [tpd_pkg::READING_W-1:0] acc_r, acc_nxt;
  logic [tpd_pkg::DEC_W-1:0]     dec_r, dec_nxt;
  logic [7:0]                    flag1_r, flag1_nxt;
  logic [7:0]                    flag2_r, flag2_nxt;
  logic                          cr_r, cr_nxt;
  logic                          in_packet_r, in_packet_nxt;

  logic                          active;
  logic [tpd_pkg::POS_W-1:0]     pos_cur;
  logic [7:0]                    pair_cur;
  logic [tpd_pkg::READING_W-1:0] acc_cur;
  logic [tpd_pkg::DEC_W-1:0]     dec_cur;
  logic [7:0]                    flag1_cur;
  logic [7:0]                    flag2_cur;
  logic                          cr_cur;
  logic [tpd_pkg::POS_W-1:0]     pos_m2;
  logic [2:0]                    slot;
  logic [7:0]                    seg;
  tpd_pkg::seg_digit_t           sd;
  logic [tpd_pkg::READING_W-1:0] digit_term;

  // start mark restarts the packet from cleared values
  assign active    = packet_start | in_packet_r;
  assign pos_cur   = packet_start ? '0 : pos_r;
  assign pair_cur  = packet_start ? '0 : pair_r;
  assign acc_cur   = packet_start ? '0 : acc_r;
  assign dec_cur   = packet_start ? '0 : dec_r;
  assign flag1_cur = packet_start ? '0 : flag1_r;
  assign flag2_cur = packet_start ? '0 : flag2_r;
  assign cr_cur    = packet_start ? 1'b0 : cr_r;

  assign pos_m2     = pos_cur - 5'd2;
  assign slot       = pos_m2[3:1];
  assign seg        = {pair_cur[3:0], data_byte[3:0]};
  assign sd         = tpd_pkg::seg_decode(seg[6:0]);
  assign digit_term = {13'd0, sd.digit} * tpd_pkg::digit_weight(slot);

  assign emit = active && (pos_cur >= tpd_pkg::POS_LAST);

  always_comb begin
    result.packet_ok    = cr_cur && (data_byte == tpd_pkg::CHAR_LF) && (|flag2_cur[1:0]);
    result.reading      = acc_cur;
    result.decimals     = dec_cur;
    result.quantity     = flag2_cur[0] ? tpd_pkg::QTY_RPM :
                          (flag2_cur[1] ? tpd_pkg::QTY_COUNT : tpd_pkg::QTY_NONE);
    result.hold_mark    = flag1_cur[2];
    result.minimum_mark = flag2_cur[5];
    result.maximum_mark = flag2_cur[4];
    result.average_mark = flag2_cur[6];
  end

  always_comb begin
    pos_nxt       = pos_r;
    pair_nxt      = pair_r;
    acc_nxt       = acc_r;
    dec_nxt       = dec_r;
    flag1_nxt     = flag1_r;
    flag2_nxt     = flag2_r;
    cr_nxt        = cr_r;
    in_packet_nxt = in_packet_r;
    if (step && active) begin
      pair_nxt      = pair_cur;
      acc_nxt       = acc_cur;
      dec_nxt       = dec_cur;
      flag1_nxt     = flag1_cur;
      flag2_nxt     = flag2_cur;
      cr_nxt        = cr_cur;
      in_packet_nxt = 1'b1;
      if (pos_cur >= tpd_pkg::POS_DIGIT_FIRST && pos_cur <= tpd_pkg::POS_DIGIT_LAST) begin
        if (pos_cur[0]) begin
          pair_nxt = data_byte;
        end else begin
          if (sd.hit) acc_nxt = acc_cur + digit_term;
          if (seg[tpd_pkg::DP_BIT]) dec_nxt = slot;
        end
      end else if (pos_cur == tpd_pkg::POS_FLAG1_HI || pos_cur == tpd_pkg::POS_FLAG2_HI) begin
        pair_nxt = data_byte;
      end else if (pos_cur == tpd_pkg::POS_FLAG1_LO) begin
        flag1_nxt = seg;
      end else if (pos_cur == tpd_pkg::POS_FLAG2_LO) begin
        flag2_nxt = seg;
      end else if (pos_cur == tpd_pkg::POS_CR) begin
        cr_nxt = (data_byte == tpd_pkg::CHAR_CR);
      end
      if (emit) begin
        in_packet_nxt = 1'b0;
        pos_nxt       = '0;
      end else begin
        pos_nxt = pos_cur + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      pair_r      <= '0;
      acc_r       <= '0;
      dec_r       <= '0;
      flag1_r     <= '0;
      flag2_r     <= '0;
      cr_r        <= 1'b0;
      in_packet_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      pair_r      <= pair_nxt;
      acc_r       <= acc_nxt;
      dec_r       <= dec_nxt;
      flag1_r     <= flag1_nxt;
      flag2_r     <= flag2_nxt;
      cr_r        <= cr_nxt;
      in_packet_r <= in_packet_nxt;
    end
  end

  // framing never runs past the trailer
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= tpd_pkg::POS_LAST)
    else $error("byte position beyond last byte");

  // outside a packet the position rests at zero
  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !in_packet_r |-> pos_r == '0)
    else $error("byte position nonzero while waiting for start");

endmodule

>>> src/tachometer_packet_decoder.sv
// ----------------------------------------------------------------------------
// tachometer_packet_decoder
// Decodes a 27-byte tachometer packet into a reading, decimal count and marks
// ----------------------------------------------------------------------------
// usage
//   in_chan takes one packet byte per request, with packet_start high on the
//   first byte of a packet; bytes seen while no packet is open are dropped
//   out_chan delivers one request per packet, after its final byte (byte 26)
//   packet_ok flags a good CR LF trailer with rpm or count mode set; a bad
//   packet still yields a request with packet_ok low
//   reading is the displayed integer, value = reading / 10**decimals
// timing
//   a byte is registered in the input stage on acceptance and decoded from there;
//   the result goes into the output register when the last byte leaves the input stage
//   one byte per cycle sustained, set by the single decode stage, unless a final byte waits on a held result
// reset
//   synchronous active-low reset clears framing and both valid flags; the
//   block then waits for a start mark
// stall
//   while a result waits on out_chan, bytes that produce no result still
//   flow; a second final byte holds in the input stage until the result goes
// ----------------------------------------------------------------------------
module tachometer_packet_decoder (
  input logic      clk,
  input logic      rst_n,
  tpd_in_if.sink   in_chan,
  tpd_out_if.source out_chan
);

  // input stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_byte_r;
  logic              s1_start_r;
  logic              s1_adv;

  // decode results
  logic              emit;
  tpd_pkg::result_t  frame_res;

  // output register
  logic              out_valid_r, out_valid_nxt;
  tpd_pkg::result_t  out_res_r;

  logic              in_take;
  logic              out_load;

  tpd_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (s1_adv),
    .data_byte    (s1_byte_r),
    .packet_start (s1_start_r),
    .emit         (emit),
    .result       (frame_res)
  );

  // the decode stage moves on unless it would overwrite a waiting result
  assign s1_adv   = s1_valid_r && (!emit || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_take  = in_chan.valid && in_chan.ready;
  assign out_load = s1_adv && emit;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take)     s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)            out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_chan.data_byte;
      s1_start_r <= in_chan.packet_start;
    end
    if (out_load) out_res_r <= frame_res;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.packet_ok    = out_res_r.packet_ok;
  assign out_chan.reading      = out_res_r.reading;
  assign out_chan.decimals     = out_res_r.decimals;
  assign out_chan.quantity     = out_res_r.quantity;
  assign out_chan.hold_mark    = out_res_r.hold_mark;
  assign out_chan.minimum_mark = out_res_r.minimum_mark;
  assign out_chan.maximum_mark = out_res_r.maximum_mark;
  assign out_chan.average_mark = out_res_r.average_mark;

  // a waiting result is never overwritten by the decode stage
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !out_load)
    else $error("result overwritten while stalled");

  // a good packet always names rpm or count
  a_ok_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.packet_ok |-> out_res_r.quantity != tpd_pkg::QTY_NONE)
    else $error("good packet without a mode");

  // five digits at most, so no more than four decimals
  a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.decimals <= 3'd4 && out_res_r.reading <= 17'd99999)
    else $error("decoded reading out of range");

endmodule
